// ----- design/accel_tilt_angles_top_macros.svh -----
// Assertion helpers shared by the tilt-angle design.
`ifndef ACCEL_TILT_ANGLES_TOP_MACROS_SVH
`define ACCEL_TILT_ANGLES_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ATA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ATA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ata_pkg.sv -----
package ata_pkg;

  localparam int ACC_W      = 16;
  localparam int GAIN_W     = 15;
  localparam int ANG_W      = 15;
  localparam int MAG_W      = 16;
  localparam int FDIV_STEPS = 16;
  localparam logic [MAG_W-1:0] CLIP_MAG = 16'd65526;

  localparam int SQ_W     = 16;
  localparam int RAD_W    = 34;
  localparam int RT_STEPS = 17;
  localparam int RT_W     = 17;
  localparam int RREM_W   = 19;

  localparam int QN_W   = 33;
  localparam int QD_W   = 18;
  localparam int QREM_W = 18;

  localparam int CORDIC_STEPS = 30;
  localparam int CXY_W        = 50;
  localparam int CZ_W         = 34;
  localparam int T_W          = 18;
  localparam int R2D_W        = 22;
  localparam logic [R2D_W-1:0] RAD_TO_DEG = 22'd3754936;
  localparam int PROD_W       = T_W + R2D_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CFG_GAIN_X = 2'd0,
    CFG_GAIN_Y = 2'd1,
    CFG_GAIN_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gx;
    logic [GAIN_W-1:0] gy;
    logic [GAIN_W-1:0] gz;
  } gain_t;

  // Scaled and clipped sample: magnitude and sign per axis.
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  localparam logic [30:0] ATAN_Q30 [11] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
    31'd1048575
  };

  function automatic logic [CZ_W-1:0] cordic_angle(input int unsigned i);
    logic [CZ_W-1:0] a;
    if (i < 11) begin
      a = CZ_W'(ATAN_Q30[i[3:0]]);
    end else begin
      a = CZ_W'(1) << (30 - i);
    end
    return a;
  endfunction

endpackage

// ----- design/ata_front.sv -----
module ata_front import ata_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gain_t            gain_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ACC_W-1:0] accel_x_i,
  input  logic [ACC_W-1:0] accel_y_i,
  input  logic [ACC_W-1:0] accel_z_i,
  output logic             item_vld_o,
  output item_t            item_o,
  input  logic             item_rdy_i
);

  localparam int NS = FDIV_STEPS + 1;

  logic              en;
  logic [NS-1:0]     vld_q;
  logic [GAIN_W-1:0] geff [3];
  logic [ACC_W-1:0]  acc [3];
  logic [MAG_W:0]    rem_q [NS][3];
  logic [MAG_W-1:0]  quo_q [NS][3];
  logic              ge_q  [NS][3];
  logic              neg_q [NS][3];

  assign acc[0] = accel_x_i;
  assign acc[1] = accel_y_i;
  assign acc[2] = accel_z_i;
  // A gain of zero divides as one.
  assign geff[0] = (gain_i.gx == '0) ? GAIN_W'(1) : gain_i.gx;
  assign geff[1] = (gain_i.gy == '0) ? GAIN_W'(1) : gain_i.gy;
  assign geff[2] = (gain_i.gz == '0) ? GAIN_W'(1) : gain_i.gz;

  assign en         = !vld_q[NS-1] || item_rdy_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_lane
    logic signed [ACC_W:0] a_s;
    logic [MAG_W:0]        a_abs;
    logic                  a_ge;

    assign a_s   = {acc[a][ACC_W-1], acc[a]};
    assign a_abs = a_s[ACC_W] ? (MAG_W+1)'(-a_s) : (MAG_W+1)'(a_s);
    // |a| >= gain means the scaled value reaches one and gets clipped.
    assign a_ge  = a_abs >= (MAG_W+1)'(geff[a]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[0][a] <= a_ge ? '0 : a_abs;
        quo_q[0][a] <= '0;
        ge_q[0][a]  <= a_ge;
        neg_q[0][a] <= acc[a][ACC_W-1];
      end
    end

    for (genvar k = 1; k < NS; k++) begin : g_step
      logic [MAG_W+1:0] r2;
      logic             take;

      assign r2   = {rem_q[k-1][a], 1'b0};
      assign take = r2 >= (MAG_W+2)'(geff[a]);

      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[k][a] <= take ? (MAG_W+1)'(r2 - (MAG_W+2)'(geff[a])) : (MAG_W+1)'(r2);
          quo_q[k][a] <= {quo_q[k-1][a][MAG_W-2:0], take};
          ge_q[k][a]  <= ge_q[k-1][a];
          neg_q[k][a] <= neg_q[k-1][a];
        end
      end
    end
  end

  assign item_vld_o = vld_q[NS-1];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      item_o.mag[a] = ge_q[NS-1][a] ? CLIP_MAG : quo_q[NS-1][a];
      item_o.neg[a] = neg_q[NS-1][a];
    end
  end

endmodule

// ----- design/ata_fifo.sv -----
`include "accel_tilt_angles_top_macros.svh"

module ata_fifo import ata_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  item_t    item_i,
  input  logic     pop_i,
  output item_t    item_o,
  output fifo_st_t st_o
);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q;
  logic [FIFO_AW-1:0] rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign st_o.full  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign st_o.empty = cnt_q == '0;
  assign item_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `ATA_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count overrun")
  `ATA_ASSERT_NEXT(a_cnt_drop, pop_i && !push_i, cnt_q == $past(cnt_q) - 1'b1, "pop lost")

endmodule

// ----- design/ata_cordic.sv -----
module ata_cordic import ata_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [1:0][QN_W-1:0]  q_i,
  input  logic [1:0]            neg_i,
  output logic                  vld_o,
  output logic [1:0][T_W-1:0]   t_o,
  output logic [1:0]            neg_o
);

  localparam int NS = CORDIC_STEPS + 1;

  logic [NS:0]              cv_q;
  logic signed [CXY_W-1:0]  x_q [NS][2];
  logic signed [CXY_W-1:0]  y_q [NS][2];
  logic signed [CZ_W-1:0]   z_q [NS][2];
  logic                     zero_q [NS][2];
  logic                     cneg_q [NS][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else if (en_i) begin
      cv_q <= {cv_q[NS-1:0], vld_i};
    end
  end

  assign vld_o = cv_q[NS];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[0][l]    <= CXY_W'(1) << 30;
        y_q[0][l]    <= $signed({3'b000, q_i[l], 14'd0});
        z_q[0][l]    <= '0;
        zero_q[0][l] <= q_i[l] == '0;
        cneg_q[0][l] <= neg_i[l];
      end
    end

    for (genvar k = 1; k < NS; k++) begin : g_step
      localparam int SH = k - 1;
      logic signed [CXY_W-1:0] xs;
      logic signed [CXY_W-1:0] ys;
      logic signed [CZ_W-1:0]  ang;
      logic                    ypos;

      assign xs   = x_q[k-1][l] >>> SH;
      assign ys   = y_q[k-1][l] >>> SH;
      assign ang  = $signed(cordic_angle(SH));
      assign ypos = !y_q[k-1][l][CXY_W-1] && (|y_q[k-1][l]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (ypos) begin
            x_q[k][l] <= x_q[k-1][l] + ys;
            y_q[k][l] <= y_q[k-1][l] - xs;
            z_q[k][l] <= z_q[k-1][l] + ang;
          end else begin
            x_q[k][l] <= x_q[k-1][l] - ys;
            y_q[k][l] <= y_q[k-1][l] + xs;
            z_q[k][l] <= z_q[k-1][l] - ang;
          end
          zero_q[k][l] <= zero_q[k-1][l];
          cneg_q[k][l] <= cneg_q[k-1][l];
        end
      end
    end

    logic [CZ_W-1:0] zc;
    logic [CZ_W-1:0] zr;

    // Clamp negative angles, round Q4.30 to Q2.16.
    assign zc = z_q[NS-1][l][CZ_W-1] ? '0 : CZ_W'(z_q[NS-1][l]);
    assign zr = (zc + CZ_W'(8192)) >> 14;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_o[l]   <= zero_q[NS-1][l] ? '0 : T_W'(zr);
        neg_o[l] <= cneg_q[NS-1][l];
      end
    end
  end

endmodule

// ----- design/ata_back.sv -----
`include "accel_tilt_angles_top_macros.svh"

module ata_back import ata_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  fifo_st_t         fst_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ANG_W-1:0] roll_centideg_o,
  output logic [ANG_W-1:0] pitch_centideg_o
);

  localparam int RNS = RT_STEPS + 1;
  localparam int DNS = QN_W + 1;

  logic en;

  // squares
  logic             sq_vld_q;
  logic [SQ_W-1:0]  sq_q [3];
  logic [MAG_W-1:0] nmag_q [2];
  logic             nneg_q [2];

  // root
  logic [RNS-1:0]    rv_q;
  logic [RREM_W-1:0] rrem_q [RNS][2];
  logic [RT_W-1:0]   rroot_q [RNS][2];
  logic [RAD_W-1:0]  rad_q [RNS][2];
  logic [MAG_W-1:0]  rnum_q [RNS][2];
  logic              rneg_q [RNS][2];

  logic              rt_vld_q;
  logic [RT_W-1:0]   rt_q [2];
  logic [MAG_W-1:0]  rtnum_q [2];
  logic              rtneg_q [2];

  // quotient
  logic [DNS-1:0]    dv_q;
  logic [QREM_W-1:0] drem_q [DNS][2];
  logic [QN_W-1:0]   dquo_q [DNS][2];
  logic [QN_W-1:0]   dn_q [DNS][2];
  logic [QD_W-1:0]   dd_q [DNS][2];
  logic              dneg_q [DNS][2];

  logic [1:0][QN_W-1:0] cq;
  logic [1:0]           cneg_in;
  logic                 c_vld;
  logic [1:0][T_W-1:0]  c_t;
  logic [1:0]           c_neg;

  logic              m_vld_q;
  logic [PROD_W-1:0] prod_q [2];
  logic              mneg_q [2];

  logic              out_vld_q;
  logic [ANG_W-1:0]  ang_q [2];

  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = en && !fst_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= 1'b0;
      rv_q      <= '0;
      rt_vld_q  <= 1'b0;
      dv_q      <= '0;
      m_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      sq_vld_q  <= !fst_i.empty;
      rv_q      <= {rv_q[RNS-2:0], sq_vld_q};
      rt_vld_q  <= rv_q[RNS-1];
      dv_q      <= {dv_q[DNS-2:0], rt_vld_q};
      m_vld_q   <= c_vld;
      out_vld_q <= m_vld_q;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_sq
    logic [2*MAG_W-1:0] p;
    logic [2*MAG_W:0]   pr;

    assign p  = (2*MAG_W)'(item_i.mag[a]) * (2*MAG_W)'(item_i.mag[a]);
    assign pr = (2*MAG_W+1)'(p) + (2*MAG_W+1)'(32768);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[a] <= SQ_W'(pr >> 16);
      end
    end
  end

  // Roll lane takes y over x,z; pitch lane takes z over x,y.
  for (genvar l = 0; l < 2; l++) begin : g_lane
    localparam int NUM = (l == 0) ? 1 : 2;
    localparam int DEN = (l == 0) ? 2 : 1;
    logic [SQ_W:0] sum;

    always_ff @(posedge clk_i) begin
      if (en) begin
        nmag_q[l] <= item_i.mag[NUM];
        nneg_q[l] <= item_i.neg[NUM];
      end
    end

    assign sum = (SQ_W+1)'(sq_q[0]) + (SQ_W+1)'(sq_q[DEN]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rrem_q[0][l]  <= '0;
        rroot_q[0][l] <= '0;
        rad_q[0][l]   <= {1'b0, sum, 16'd0};
        rnum_q[0][l]  <= nmag_q[l];
        rneg_q[0][l]  <= nneg_q[l];
      end
    end

    for (genvar k = 1; k < RNS; k++) begin : g_root
      logic [RREM_W+1:0] r4;
      logic [RREM_W+1:0] trial;
      logic              take;

      assign r4    = {rrem_q[k-1][l], rad_q[k-1][l][RAD_W-1 -: 2]};
      assign trial = {2'b00, rroot_q[k-1][l], 2'b01};
      assign take  = r4 >= trial;

      always_ff @(posedge clk_i) begin
        if (en) begin
          rrem_q[k][l]  <= take ? RREM_W'(r4 - trial) : RREM_W'(r4);
          rroot_q[k][l] <= {rroot_q[k-1][l][RT_W-2:0], take};
          rad_q[k][l]   <= rad_q[k-1][l] << 2;
          rnum_q[k][l]  <= rnum_q[k-1][l];
          rneg_q[k][l]  <= rneg_q[k-1][l];
        end
      end
    end

    logic [RT_W-1:0] rr;

    // Round to nearest; a zero root counts as one LSB.
    always_comb begin
      rr = rroot_q[RNS-1][l];
      if (rrem_q[RNS-1][l] > RREM_W'(rroot_q[RNS-1][l])) begin
        rr = rroot_q[RNS-1][l] + RT_W'(1);
      end
      if (rr == '0) begin
        rr = RT_W'(1);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_q[l]    <= rr;
        rtnum_q[l] <= rnum_q[RNS-1][l];
        rtneg_q[l] <= rneg_q[RNS-1][l];
      end
    end

    // q = (2*mag*65536 + root) / (2*root)
    always_ff @(posedge clk_i) begin
      if (en) begin
        drem_q[0][l] <= '0;
        dquo_q[0][l] <= '0;
        dn_q[0][l]   <= {rtnum_q[l], {(QN_W-MAG_W){1'b0}}} + QN_W'(rt_q[l]);
        dd_q[0][l]   <= {rt_q[l], 1'b0};
        dneg_q[0][l] <= rtneg_q[l];
      end
    end

    for (genvar k = 1; k < DNS; k++) begin : g_div
      logic [QREM_W:0] r2;
      logic            take;

      assign r2   = {drem_q[k-1][l], dn_q[k-1][l][QN_W-1]};
      assign take = r2 >= (QREM_W+1)'(dd_q[k-1][l]);

      always_ff @(posedge clk_i) begin
        if (en) begin
          drem_q[k][l] <= take ? QREM_W'(r2 - (QREM_W+1)'(dd_q[k-1][l])) : QREM_W'(r2);
          dquo_q[k][l] <= {dquo_q[k-1][l][QN_W-2:0], take};
          dn_q[k][l]   <= dn_q[k-1][l] << 1;
          dd_q[k][l]   <= dd_q[k-1][l];
          dneg_q[k][l] <= dneg_q[k-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q[l] <= PROD_W'(c_t[l]) * PROD_W'(RAD_TO_DEG);
        mneg_q[l] <= c_neg[l];
      end
    end

    logic [PROD_W:0]          dsum;
    logic [PROD_W-16:0]       dmag;
    logic signed [PROD_W-15:0] sd;
    logic signed [32:0]       pc;
    logic signed [32:0]       res;

    assign dsum = (PROD_W+1)'(prod_q[l]) + (PROD_W+1)'(32768);
    assign dmag = dsum[PROD_W:16];
    assign sd   = mneg_q[l] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    assign pc   = 33'(sd) * 33'sd100;
    assign res  = pc >>> 16;

    always_ff @(posedge clk_i) begin
      if (en) begin
        ang_q[l] <= res[ANG_W-1:0];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cq[l]      = dquo_q[DNS-1][l];
      cneg_in[l] = dneg_q[DNS-1][l];
    end
  end

  ata_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_q[DNS-1]),
    .q_i    (cq),
    .neg_i  (cneg_in),
    .vld_o  (c_vld),
    .t_o    (c_t),
    .neg_o  (c_neg)
  );

  assign out_valid_o      = out_vld_q;
  assign roll_centideg_o  = ang_q[0];
  assign pitch_centideg_o = ang_q[1];

  `ATA_ASSERT_NEXT(a_pop_fill, pop_o, sq_vld_q, "popped item did not enter square stage")

endmodule

// ----- design/accel_tilt_angles_top.sv -----
// Throughput: one sample per cycle while the output is ready and the queue is not full;
// every step (scale divide, square root, quotient divide, CORDIC) is a pipeline stage,
// one result bit or one rotation each, and a 4-entry queue sits between scaling and the
// back end.
// Reset: asynchronous, active low; clears the pipeline valid bits and the queue state and sets each gain to 16383.
module accel_tilt_angles_top import ata_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [GAIN_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ACC_W-1:0]  accel_x_i,
  input  logic [ACC_W-1:0]  accel_y_i,
  input  logic [ACC_W-1:0]  accel_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ANG_W-1:0]  roll_centideg_o,
  output logic [ANG_W-1:0]  pitch_centideg_o
);

  gain_t    gain_q;
  logic     f_vld;
  item_t    f_item;
  item_t    q_item;
  fifo_st_t q_st;
  logic     push;
  logic     pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q.gx <= GAIN_W'(16383);
      gain_q.gy <= GAIN_W'(16383);
      gain_q.gz <= GAIN_W'(16383);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_X: gain_q.gx <= cfg_wdata_i;
        CFG_GAIN_Y: gain_q.gy <= cfg_wdata_i;
        CFG_GAIN_Z: gain_q.gz <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign push = f_vld && !q_st.full;

  ata_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gain_i     (gain_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .accel_x_i  (accel_x_i),
    .accel_y_i  (accel_y_i),
    .accel_z_i  (accel_z_i),
    .item_vld_o (f_vld),
    .item_o     (f_item),
    .item_rdy_i (!q_st.full)
  );

  ata_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (q_item),
    .st_o   (q_st)
  );

  ata_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (q_item),
    .fst_i            (q_st),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .roll_centideg_o  (roll_centideg_o),
    .pitch_centideg_o (pitch_centideg_o)
  );

endmodule

// ----- verif/tb_accel_tilt_angles_top.sv -----
`timescale 1ns / 1ps

module tb_accel_tilt_angles_top;
  import ata_pkg::*;

  typedef struct {
    logic [ACC_W-1:0] ax;
    logic [ACC_W-1:0] ay;
    logic [ACC_W-1:0] az;
  } sample_t;

  typedef struct {
    logic [ANG_W-1:0] roll;
    logic [ANG_W-1:0] pitch;
  } angles_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_STALL     = 400;
  localparam int DRAIN_CYCLES   = 200;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  logic [GAIN_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic [ACC_W-1:0] accel_x;
  logic [ACC_W-1:0] accel_y;
  logic [ACC_W-1:0] accel_z;
  logic             out_valid;
  logic             out_ready;
  logic [ANG_W-1:0] roll;
  logic [ANG_W-1:0] pitch;

  sample_t samples_q[$];
  angles_t angles_q[$];
  int unsigned gain_cur [3];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          long_stall_go;
  bit          long_stall_done;
  int          stall_left;
  int          quiet_cycles;
  int          errors;

  accel_tilt_angles_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .accel_x_i       (accel_x),
    .accel_y_i       (accel_y),
    .accel_z_i       (accel_z),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .roll_centideg_o (roll),
    .pitch_centideg_o(pitch)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Scale raw counts to Q16.16 and clip just inside +/-1.0.
  function automatic longint scale_counts(logic [ACC_W-1:0] raw, int unsigned gain);
    longint a;
    longint g;
    longint s;
    a = longint'($signed(raw));
    g = (gain == 0) ? 1 : longint'(gain);
    s = (a * 65536) / g;
    if (s >= 65536) s = 65536 - 10;
    else if (s <= -65536) s = -65536 + 10;
    return s;
  endfunction

  function automatic longint unsigned root_rounded(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    longint unsigned x;
    r = 0;
    b = 64'd1 << 62;
    x = n;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n - r * r > r) r = r + 1;
    return r;
  endfunction

  // Arctangent of a Q16.16 ratio by vectoring rotations, result Q16.16.
  function automatic longint atan_q16(longint unsigned q);
    longint cx;
    longint cy;
    longint cz;
    longint nx;
    longint ny;
    longint ang;
    cx = 64'sd1 << 30;
    cz = 0;
    if (q == 0) return 0;
    cy = longint'(q << 14);
    for (int i = 0; i < 30; i++) begin
      ang = (i < 11) ? longint'(ATAN_Q30[i]) : (64'sd1 << (30 - i));
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        cz = cz + ang;
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        cz = cz - ang;
      end
      cx = nx;
      cy = ny;
    end
    if (cz < 0) cz = 0;
    return (cz + 8192) >>> 14;
  endfunction

  function automatic logic [ANG_W-1:0] tilt_angle(longint num, longint da, longint db);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned sum;
    longint unsigned rt;
    longint unsigned mag;
    longint unsigned q;
    longint t;
    longint d;
    longint p;
    ma = longint'(da < 0 ? -da : da);
    mb = longint'(db < 0 ? -db : db);
    sum = ((ma * ma + 32768) >> 16) + ((mb * mb + 32768) >> 16);
    rt = root_rounded(sum << 16);
    mag = longint'(num < 0 ? -num : num);
    if (rt == 0) rt = 1;
    q = (2 * mag * 65536 + rt) / (2 * rt);
    t = atan_q16(q);
    d = (t * 3754936 + 32768) >>> 16;
    if (num < 0) d = -d;
    p = d * 100;
    return ANG_W'(p >>> 16);
  endfunction

  function automatic angles_t predict_tilt(sample_t s);
    angles_t r;
    longint sx;
    longint sy;
    longint sz;
    sx = scale_counts(s.ax, gain_cur[0]);
    sy = scale_counts(s.ay, gain_cur[1]);
    sz = scale_counts(s.az, gain_cur[2]);
    r.roll  = tilt_angle(sy, sx, sz);
    r.pitch = tilt_angle(sz, sx, sy);
    return r;
  endfunction

  // Driver: hold the payload until transfer, then offer the next sample.
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      accel_x  <= '0;
      accel_y  <= '0;
      accel_z  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s.ax = accel_x;
        s.ay = accel_y;
        s.az = accel_z;
        angles_q.push_back(predict_tilt(s));
      end
      if (!in_valid || in_ready) begin
        if (samples_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s = samples_q.pop_front();
          in_valid <= 1'b1;
          accel_x  <= s.ax;
          accel_y  <= s.ay;
          accel_z  <= s.az;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction and drive random stalls on out_ready.
  always @(posedge clk_i or negedge rst_ni) begin
    angles_t e;
    if (!rst_ni) begin
      out_ready       <= 1'b0;
      stall_left      <= 0;
      long_stall_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (angles_q.size() == 0) begin
          $display("%0t: unexpected result roll=%0d pitch=%0d", $time,
                   $signed(roll), $signed(pitch));
          errors++;
        end else begin
          e = angles_q.pop_front();
          if (roll !== e.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time,
                     $signed(e.roll), $signed(roll));
            errors++;
          end
          if (pitch !== e.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time,
                     $signed(e.pitch), $signed(pitch));
            errors++;
          end
        end
      end
      if (long_stall_go && !long_stall_done) begin
        long_stall_done <= 1'b1;
        stall_left      <= LONG_STALL;
        out_ready       <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (samples_q.size() == 0 && angles_q.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_gain(cfg_idx_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= GAIN_W'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    gain_cur[idx] = value;
  endtask

  task automatic queue_sample(int ax, int ay, int az);
    sample_t s;
    s.ax = ACC_W'(ax);
    s.ay = ACC_W'(ay);
    s.az = ACC_W'(az);
    samples_q.push_back(s);
  endtask

  task automatic wait_drained();
    while (samples_q.size() > 0 || angles_q.size() > 0 || in_valid) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly samples within +/- one g of an axis gain on all axes, the rest full range.
  task automatic queue_random(int n);
    int g;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(2) == 0) begin
        queue_sample($urandom, $urandom, $urandom);
      end else begin
        g = (gain_cur[$urandom_range(2)] == 0) ? 1 : gain_cur[$urandom_range(2)];
        queue_sample($urandom_range(2 * g) - g, $urandom_range(2 * g) - g,
                     $urandom_range(2 * g) - g);
      end
    end
  endtask

  initial begin
    int unsigned ph_send [4];
    int unsigned ph_recv [4];
    ph_send        = '{0, 46, 0, 20};
    ph_recv        = '{0, 0, 46, 20};
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_GAIN_X;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_stall_go  = 1'b0;
    errors         = 0;
    gain_cur       = '{16383, 16383, 16383};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples at reset gains: zeros, extremes, single axes.
    queue_sample(0, 0, 0);
    queue_sample(32767, 32767, 32767);
    queue_sample(-32768, -32768, -32768);
    queue_sample(16383, 0, 0);
    queue_sample(0, 16383, 0);
    queue_sample(0, 0, 16383);
    queue_sample(0, -16383, 0);
    queue_sample(0, 0, -16384);
    queue_sample(-32768, 32767, 0);
    queue_sample(1, -1, 1);
    queue_sample(0, 1, -1);
    queue_sample(16383, 16383, 0);
    queue_sample(-1, 0, 0);
    queue_sample(100, -200, 16000);
    wait_drained();

    // Extreme gains, including zero taken as one.
    write_gain(CFG_GAIN_X, 1);
    write_gain(CFG_GAIN_Y, 32767);
    write_gain(CFG_GAIN_Z, 0);
    queue_sample(1, 32767, 1);
    queue_sample(-1, -32768, -1);
    queue_sample(0, 0, 0);
    queue_sample(0, 16384, 0);
    queue_sample(32767, -32768, 32767);
    queue_sample(0, 1, 0);
    queue_sample(0, -1, 1);
    queue_sample(5, 0, -5);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = ph_send[ph];
      recv_stall_pct = ph_recv[ph];
      if (ph == 3) begin
        write_gain(CFG_GAIN_X, 32767);
        write_gain(CFG_GAIN_Y, 1);
        write_gain(CFG_GAIN_Z, 16383);
      end else begin
        write_gain(CFG_GAIN_X, $urandom_range(32767, 1));
        write_gain(CFG_GAIN_Y, $urandom_range(32767, 1));
        write_gain(CFG_GAIN_Z, $urandom_range(32767, 1));
      end
      queue_random(500);
      // Starve the output while the sender keeps offering samples.
      if (ph == 0) long_stall_go = 1'b1;
      wait_drained();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
